/* rtl/reflector_peer_session_table_core_macros.svh */
// Assertion macros shared by the peer session table RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef REFLECTOR_PEER_SESSION_TABLE_CORE_MACROS_SVH
`define REFLECTOR_PEER_SESSION_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define RPST_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define RPST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rpst_pkg.sv */
// Package for the peer session table: entry type, codes, states and constants.
// Used by the table cell, the cell ring and the top level.
package rpst_pkg;

   localparam int PeerSlotsDefault = 16;

   localparam logic [31:0] SigDsvt  = 32'h44535654;
   localparam logic [7:0]  ModSpace = 8'h20;
   localparam logic [7:0]  ModQuit  = 8'h51;

   // One table entry as it travels along the ring.
   typedef struct packed {
      logic               valid;
      logic [63:0]        addr_hi;
      logic [63:0]        addr_lo;
      logic [15:0]        port;
      logic [7:0]         module_id;
      logic [15:0]        idle;
      logic signed [16:0] countdown;
   } entry_type;

   typedef enum logic [3:0] {
      CODE_IGNORED   = 4'd0,
      CODE_REFRESHED = 4'd1,
      CODE_BIND_ACK  = 4'd2,
      CODE_UNBOUND   = 4'd3,
      CODE_FULL      = 4'd4,
      CODE_BAD_LEN   = 4'd5,
      CODE_BAD_SIG   = 4'd6,
      CODE_KA_DUE    = 4'd7,
      CODE_EVICTED   = 4'd8,
      CODE_TICK_DONE = 4'd9
   } code_type;

   typedef enum logic [2:0] {
      REG_KA_LEN     = 3'd0,
      REG_BIND_LEN   = 3'd1,
      REG_ANSWER_LEN = 3'd2,
      REG_HEADER_LEN = 3'd3,
      REG_FRAME_LEN  = 3'd4,
      REG_DEAD_LIMIT = 3'd5,
      REG_KA_PERIOD  = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY,
      ST_RESPOND,
      ST_TICK,
      ST_TICK_DONE
   } state_type;

   typedef enum logic [2:0] {
      CLS_KEEPALIVE,
      CLS_BIND,
      CLS_ANSWER,
      CLS_STREAM,
      CLS_BAD
   } class_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_REFRESH,
      OP_UNBIND,
      OP_BIND
   } op_type;

endpackage

/* rtl/rpst_cell.sv */
// One cell of the session ring: holds a single table entry.
// Depends on rpst_pkg for the entry type.
module rpst_cell
   import rpst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  entry_type entry_in,
   output entry_type entry_out
);

   entry_type entry_ff;

   // The valid bit is control state and clears at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (shift) begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   // The payload moves with the valid bit but needs no reset.
   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff.addr_hi   <= entry_in.addr_hi;
         entry_ff.addr_lo   <= entry_in.addr_lo;
         entry_ff.port      <= entry_in.port;
         entry_ff.module_id <= entry_in.module_id;
         entry_ff.idle      <= entry_in.idle;
         entry_ff.countdown <= entry_in.countdown;
      end
   end

   assign entry_out = entry_ff;

endmodule

/* rtl/rpst_ring.sv */
// Ring of table cells; the head cell is read and the written-back entry enters at the tail.
// Depends on rpst_pkg and rpst_cell.
module rpst_ring
   import rpst_pkg::*;
#(
   parameter int PEER_SLOTS = PeerSlotsDefault
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  entry_type tail_in,
   output entry_type head_out
);

   entry_type cell_out [PEER_SLOTS];

   // Each cell takes its neighbor's entry; the last cell takes the write-back.
   for (genvar k = 0; k < PEER_SLOTS; k++) begin : g_cell
      entry_type cell_in;
      if (k == PEER_SLOTS - 1) begin : g_tail
         assign cell_in = tail_in;
      end else begin : g_mid
         assign cell_in = cell_out[k+1];
      end
      rpst_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .entry_in  (cell_in),
         .entry_out (cell_out[k])
      );
   end

   assign head_out = cell_out[0];

endmodule

/* rtl/reflector_peer_session_table_core.sv */
// Peer session table top level: command port, result strobe, register port, control.
// Depends on rpst_pkg, rpst_ring and the assertion macro header.
//
// Usage: raise start with the req_ fields while busy is low; the beat is taken
// at that edge. A packet beat walks the ring twice, once to search for the peer
// and a free slot and once to apply the change, then gives one result. A tick
// beat walks the ring once and emits one result per eviction or keepalive due
// as the slot passes the head cell, then a tick-done result with rsp_last set.
// The ring presents one slot per cycle at its head while it walks. Each result
// shows on the rsp_ ports for one cycle with rsp_valid high; the receiver
// cannot stall, and the block never waits on it.
// Registers sit on the APB-style port at byte address 4*index. The user must
// write them only while busy is low; the block itself does not enforce it.
// Reset clears all slots, the error count and restores register defaults; no
// clearing pass is needed.
`include "reflector_peer_session_table_core_macros.svh"

module reflector_peer_session_table_core
   import rpst_pkg::*;
#(
   parameter int PEER_SLOTS = PeerSlotsDefault
) (
   input  logic        clock,
   input  logic        reset,
   // Command channel
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [63:0] req_addr_hi,
   input  logic [63:0] req_addr_lo,
   input  logic [15:0] req_src_port,
   input  logic [11:0] req_pkt_len,
   input  logic [7:0]  req_module_byte,
   input  logic [31:0] req_signature,
   // Result channel
   output logic        rsp_valid,
   output logic [3:0]  rsp_code,
   output logic [3:0]  rsp_slot,
   output logic [63:0] rsp_peer_addr_hi,
   output logic [63:0] rsp_peer_addr_lo,
   output logic [15:0] rsp_peer_port,
   output logic [31:0] rsp_error_total,
   output logic        rsp_last,
   // Register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam logic [CW-1:0] LastSlot = CW'(PEER_SLOTS - 1);

   // Configuration registers.
   logic [11:0] ka_len_ff, bind_len_ff, answer_len_ff, header_len_ff, frame_len_ff;
   logic [15:0] dead_limit_ff, ka_period_ff;
   logic        cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ka_len_ff     <= 12'd9;
         bind_len_ff   <= 12'd11;
         answer_len_ff <= 12'd14;
         header_len_ff <= 12'd56;
         frame_len_ff  <= 12'd27;
         dead_limit_ff <= 16'd30;
         ka_period_ff  <= 16'd3;
      end else if (cfg_write) begin
         case (reg_index_type'(paddr[4:2]))
            REG_KA_LEN:     ka_len_ff     <= pwdata[11:0];
            REG_BIND_LEN:   bind_len_ff   <= pwdata[11:0];
            REG_ANSWER_LEN: answer_len_ff <= pwdata[11:0];
            REG_HEADER_LEN: header_len_ff <= pwdata[11:0];
            REG_FRAME_LEN:  frame_len_ff  <= pwdata[11:0];
            REG_DEAD_LIMIT: dead_limit_ff <= pwdata[15:0];
            REG_KA_PERIOD:  ka_period_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (reg_index_type'(paddr[4:2]))
         REG_KA_LEN:     prdata = {20'd0, ka_len_ff};
         REG_BIND_LEN:   prdata = {20'd0, bind_len_ff};
         REG_ANSWER_LEN: prdata = {20'd0, answer_len_ff};
         REG_HEADER_LEN: prdata = {20'd0, header_len_ff};
         REG_FRAME_LEN:  prdata = {20'd0, frame_len_ff};
         REG_DEAD_LIMIT: prdata = {16'd0, dead_limit_ff};
         REG_KA_PERIOD:  prdata = {16'd0, ka_period_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // Control and item registers.
   state_type   state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   class_type   class_ff, class_in;
   logic [63:0] hi_ff, lo_ff;
   logic [15:0] port_ff;
   logic [7:0]  mod_ff;
   logic        sig_ok_ff;
   logic        found_ff, found_in, free_ff, free_in;
   logic [CW-1:0] fslot_ff, fslot_in, freeslot_ff, freeslot_in;
   op_type      op_ff, op_in;
   logic [CW-1:0] tgt_ff, tgt_in;
   code_type    code_ff, code_in;
   logic [CW-1:0] rslot_ff, rslot_in;
   logic [31:0] error_ff, error_in;
   logic        accept;

   // Result registers.
   logic        rsp_valid_ff, rsp_valid_in;
   code_type    rsp_code_ff, rsp_code_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic [63:0] rsp_hi_ff, rsp_hi_in, rsp_lo_ff, rsp_lo_in;
   logic [15:0] rsp_port_ff, rsp_port_in;
   logic [31:0] rsp_error_ff, rsp_error_in;
   logic        rsp_last_ff, rsp_last_in;

   // Ring signals.
   entry_type   head, wb;
   logic        shift;
   logic        match, mod_quit, found_now, free_now;
   logic [CW-1:0] fslot_now, freeslot_now;
   logic [15:0] idle_next;
   logic signed [16:0] cd_next;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;
   assign shift  = (state_ff == ST_SEARCH) | (state_ff == ST_APPLY) | (state_ff == ST_TICK);

   rpst_ring #(.PEER_SLOTS(PEER_SLOTS)) u_ring (
      .clock    (clock),
      .reset    (reset),
      .shift    (shift),
      .tail_in  (wb),
      .head_out (head)
   );

   assign match = head.valid && (head.addr_hi == hi_ff) && (head.addr_lo == lo_ff)
                  && (head.port == port_ff);
   assign found_now    = found_ff | match;
   assign fslot_now    = found_ff ? fslot_ff : cnt_ff;
   assign free_now     = free_ff | ~head.valid;
   assign freeslot_now = free_ff ? freeslot_ff : cnt_ff;
   assign mod_quit     = (mod_ff == ModSpace) || (mod_ff == ModQuit);
   assign idle_next    = (head.idle == 16'hFFFF) ? head.idle : head.idle + 16'd1;
   assign cd_next      = head.countdown - 17'sd1;

   // Next state, ring write-back and result generation.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      class_in     = class_ff;
      found_in     = found_ff;
      fslot_in     = fslot_ff;
      free_in      = free_ff;
      freeslot_in  = freeslot_ff;
      op_in        = op_ff;
      tgt_in       = tgt_ff;
      code_in      = code_ff;
      rslot_in     = rslot_ff;
      error_in     = error_ff;
      wb           = head;
      rsp_valid_in = 1'b0;
      rsp_code_in  = CODE_IGNORED;
      rsp_slot_in  = 4'd0;
      rsp_hi_in    = 64'd0;
      rsp_lo_in    = 64'd0;
      rsp_port_in  = 16'd0;
      rsp_error_in = error_ff;
      rsp_last_in  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in   = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
               if (req_pkt_len == ka_len_ff) begin
                  class_in = CLS_KEEPALIVE;
               end else if (req_pkt_len == bind_len_ff) begin
                  class_in = CLS_BIND;
               end else if (req_pkt_len == answer_len_ff) begin
                  class_in = CLS_ANSWER;
               end else if (req_pkt_len == header_len_ff || req_pkt_len == frame_len_ff) begin
                  class_in = CLS_STREAM;
               end else begin
                  class_in = CLS_BAD;
               end
               if (req_action) begin
                  state_in = ST_TICK;
               end else begin
                  state_in = ST_SEARCH;
                  if (class_in == CLS_BAD) begin
                     error_in = error_ff + 32'd1;
                  end
               end
            end
         end

         ST_SEARCH: begin
            found_in    = found_now;
            fslot_in    = fslot_now;
            free_in     = free_now;
            freeslot_in = freeslot_now;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == LastSlot) begin
               cnt_in   = '0;
               state_in = ST_APPLY;
               op_in    = OP_NONE;
               tgt_in   = fslot_now;
               code_in  = CODE_IGNORED;
               rslot_in = '0;
               case (class_ff)
                  CLS_KEEPALIVE: begin
                     if (found_now) begin
                        op_in    = OP_REFRESH;
                        code_in  = CODE_REFRESHED;
                        rslot_in = fslot_now;
                     end
                  end
                  CLS_BIND: begin
                     if (mod_quit) begin
                        if (found_now) begin
                           op_in    = OP_UNBIND;
                           code_in  = CODE_UNBOUND;
                           rslot_in = fslot_now;
                        end
                     end else if (found_now) begin
                        code_in  = CODE_BIND_ACK;
                        rslot_in = fslot_now;
                     end else if (free_now) begin
                        op_in    = OP_BIND;
                        tgt_in   = freeslot_now;
                        code_in  = CODE_BIND_ACK;
                        rslot_in = freeslot_now;
                     end else begin
                        code_in = CODE_FULL;
                     end
                  end
                  CLS_ANSWER: begin
                     if (found_now) begin
                        rslot_in = fslot_now;
                     end
                  end
                  CLS_STREAM: begin
                     if (found_now) begin
                        rslot_in = fslot_now;
                        if (sig_ok_ff) begin
                           op_in   = OP_REFRESH;
                           code_in = CODE_REFRESHED;
                        end else begin
                           code_in = CODE_BAD_SIG;
                        end
                     end
                  end
                  default: begin
                     code_in = CODE_BAD_LEN;
                  end
               endcase
            end
         end

         ST_APPLY: begin
            if (cnt_ff == tgt_ff) begin
               case (op_ff)
                  OP_REFRESH: wb.idle  = 16'd0;
                  OP_UNBIND:  wb.valid = 1'b0;
                  OP_BIND: begin
                     wb.valid     = 1'b1;
                     wb.addr_hi   = hi_ff;
                     wb.addr_lo   = lo_ff;
                     wb.port      = port_ff;
                     wb.module_id = mod_ff;
                     wb.idle      = 16'd0;
                     wb.countdown = {1'b0, ka_period_ff};
                  end
                  default: ;
               endcase
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastSlot) begin
               cnt_in   = '0;
               state_in = ST_RESPOND;
            end
         end

         ST_RESPOND: begin
            rsp_valid_in = 1'b1;
            rsp_code_in  = code_ff;
            rsp_last_in  = 1'b1;
            if (code_ff != CODE_BAD_LEN) begin
               rsp_slot_in = 4'(rslot_ff);
               rsp_hi_in   = hi_ff;
               rsp_lo_in   = lo_ff;
               rsp_port_in = port_ff;
            end
            state_in = ST_IDLE;
         end

         ST_TICK: begin
            // Age the head entry; evict or flag a keepalive as it passes.
            if (head.valid) begin
               wb.idle     = idle_next;
               rsp_slot_in = 4'(cnt_ff);
               rsp_hi_in   = head.addr_hi;
               rsp_lo_in   = head.addr_lo;
               rsp_port_in = head.port;
               if (idle_next > dead_limit_ff) begin
                  wb.valid     = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = CODE_EVICTED;
               end else begin
                  wb.countdown = cd_next;
                  if (cd_next < 0) begin
                     wb.countdown = {1'b0, ka_period_ff};
                     rsp_valid_in = 1'b1;
                     rsp_code_in  = CODE_KA_DUE;
                  end
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastSlot) begin
               cnt_in   = '0;
               state_in = ST_TICK_DONE;
            end
         end

         ST_TICK_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_code_in  = CODE_TICK_DONE;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         error_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload.
   always_ff @(posedge clock) begin
      class_ff     <= class_in;
      found_ff     <= found_in;
      fslot_ff     <= fslot_in;
      free_ff      <= free_in;
      freeslot_ff  <= freeslot_in;
      op_ff        <= op_in;
      tgt_ff       <= tgt_in;
      code_ff      <= code_in;
      rslot_ff     <= rslot_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_hi_ff    <= rsp_hi_in;
      rsp_lo_ff    <= rsp_lo_in;
      rsp_port_ff  <= rsp_port_in;
      rsp_error_ff <= rsp_error_in;
      rsp_last_ff  <= rsp_last_in;
      if (accept) begin
         hi_ff     <= req_addr_hi;
         lo_ff     <= req_addr_lo;
         port_ff   <= req_src_port;
         mod_ff    <= req_module_byte;
         sig_ok_ff <= (req_signature == SigDsvt);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code         = rsp_code_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_peer_addr_hi = rsp_hi_ff;
   assign rsp_peer_addr_lo = rsp_lo_ff;
   assign rsp_peer_port    = rsp_port_ff;
   assign rsp_error_total  = rsp_error_ff;
   assign rsp_last         = rsp_last_ff;

   // Checks on the control flow.
   `RPST_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "accepted beat did not raise busy")
   `RPST_ASSERT_NEXT(a_last_quiet, clock, reset, rsp_valid && rsp_last, !rsp_valid, "result strobe right after a final beat")
   `RPST_ASSERT_NOW(a_tick_last, clock, reset, rsp_valid && rsp_code == CODE_TICK_DONE, rsp_last, "tick-done result without last")
   `RPST_ASSERT_NOW(a_badlen_zero, clock, reset, rsp_valid && rsp_code == CODE_BAD_LEN, rsp_slot == 4'd0 && rsp_peer_port == 16'd0, "bad-length result carries a peer")

endmodule

/* dv/session_table_checker.sv */
`timescale 1ns / 1ps
// Checker for the peer session table: watches the command, result and register ports,
// predicts every result beat and compares it. Depends on rpst_pkg.
module session_table_checker
   import rpst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_action,
   input  logic [63:0] req_addr_hi,
   input  logic [63:0] req_addr_lo,
   input  logic [15:0] req_src_port,
   input  logic [11:0] req_pkt_len,
   input  logic [7:0]  req_module_byte,
   input  logic [31:0] req_signature,
   input  logic        rsp_valid,
   input  logic [3:0]  rsp_code,
   input  logic [3:0]  rsp_slot,
   input  logic [63:0] rsp_peer_addr_hi,
   input  logic [63:0] rsp_peer_addr_lo,
   input  logic [15:0] rsp_peer_port,
   input  logic [31:0] rsp_error_total,
   input  logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          mismatch_count,
   output int          results_pending
);

   localparam int Slots = 16;

   typedef struct {
      code_type    code;
      logic [3:0]  slot;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [15:0] port;
      logic [31:0] err;
      logic        last;
   } session_result_type;

   session_result_type expected_results[$];

   // Shadow copy of the registers.
   logic [11:0] ka_len, bind_len, answer_len, header_len, frame_len;
   logic [15:0] dead_limit, ka_period;

   // Shadow copy of the peer table.
   logic               peer_valid[Slots];
   logic [63:0]        peer_hi[Slots];
   logic [63:0]        peer_lo[Slots];
   logic [15:0]        peer_port[Slots];
   logic [15:0]        peer_idle[Slots];
   logic signed [16:0] peer_countdown[Slots];
   logic [31:0]        bad_length_count;

   assign results_pending = expected_results.size();

   function automatic void push_result(code_type code, int slot, logic [63:0] hi,
                                       logic [63:0] lo, logic [15:0] port, logic last);
      session_result_type r;
      r.code = code;
      r.slot = slot[3:0];
      r.hi   = hi;
      r.lo   = lo;
      r.port = port;
      r.err  = bad_length_count;
      r.last = last;
      expected_results.push_back(r);
   endfunction

   // Work out the results of one accepted beat and update the shadow table.
   function automatic void predict_session_results();
      int found;
      int free_slot;
      found = -1;
      free_slot = -1;
      if (req_action) begin
         // A tick ages every bound peer in ascending slot order.
         for (int i = 0; i < Slots; i++) begin
            if (!peer_valid[i]) continue;
            if (peer_idle[i] != 16'hFFFF) peer_idle[i]++;
            if (peer_idle[i] > dead_limit) begin
               peer_valid[i] = 1'b0;
               push_result(CODE_EVICTED, i, peer_hi[i], peer_lo[i], peer_port[i], 1'b0);
               continue;
            end
            peer_countdown[i] = peer_countdown[i] - 17'sd1;
            if (peer_countdown[i] < 0) begin
               peer_countdown[i] = $signed({1'b0, ka_period});
               push_result(CODE_KA_DUE, i, peer_hi[i], peer_lo[i], peer_port[i], 1'b0);
            end
         end
         push_result(CODE_TICK_DONE, 0, '0, '0, '0, 1'b1);
         return;
      end

      for (int i = 0; i < Slots; i++) begin
         if (found < 0 && peer_valid[i] && peer_hi[i] == req_addr_hi &&
             peer_lo[i] == req_addr_lo && peer_port[i] == req_src_port)
            found = i;
         if (free_slot < 0 && !peer_valid[i]) free_slot = i;
      end

      // Length classes are tried in fixed priority order.
      if (req_pkt_len == ka_len) begin
         if (found < 0) begin
            push_result(CODE_IGNORED, 0, req_addr_hi, req_addr_lo, req_src_port, 1'b1);
         end else begin
            peer_idle[found] = '0;
            push_result(CODE_REFRESHED, found, req_addr_hi, req_addr_lo, req_src_port, 1'b1);
         end
      end else if (req_pkt_len == bind_len) begin
         if (req_module_byte == ModSpace || req_module_byte == ModQuit) begin
            if (found < 0) begin
               push_result(CODE_IGNORED, 0, req_addr_hi, req_addr_lo, req_src_port, 1'b1);
            end else begin
               peer_valid[found] = 1'b0;
               push_result(CODE_UNBOUND, found, req_addr_hi, req_addr_lo, req_src_port, 1'b1);
            end
         end else if (found >= 0) begin
            push_result(CODE_BIND_ACK, found, req_addr_hi, req_addr_lo, req_src_port, 1'b1);
         end else if (free_slot < 0) begin
            push_result(CODE_FULL, 0, req_addr_hi, req_addr_lo, req_src_port, 1'b1);
         end else begin
            peer_valid[free_slot]     = 1'b1;
            peer_hi[free_slot]        = req_addr_hi;
            peer_lo[free_slot]        = req_addr_lo;
            peer_port[free_slot]      = req_src_port;
            peer_idle[free_slot]      = '0;
            peer_countdown[free_slot] = $signed({1'b0, ka_period});
            push_result(CODE_BIND_ACK, free_slot, req_addr_hi, req_addr_lo, req_src_port,
                        1'b1);
         end
      end else if (req_pkt_len == answer_len) begin
         push_result(CODE_IGNORED, (found < 0) ? 0 : found, req_addr_hi, req_addr_lo,
                     req_src_port, 1'b1);
      end else if (req_pkt_len == header_len || req_pkt_len == frame_len) begin
         // The peer lookup comes before the signature check.
         if (found < 0) begin
            push_result(CODE_IGNORED, 0, req_addr_hi, req_addr_lo, req_src_port, 1'b1);
         end else if (req_signature != SigDsvt) begin
            push_result(CODE_BAD_SIG, found, req_addr_hi, req_addr_lo, req_src_port, 1'b1);
         end else begin
            peer_idle[found] = '0;
            push_result(CODE_REFRESHED, found, req_addr_hi, req_addr_lo, req_src_port, 1'b1);
         end
      end else begin
         bad_length_count = bad_length_count + 32'd1;
         push_result(CODE_BAD_LEN, 0, '0, '0, '0, 1'b1);
      end
   endfunction

   // Compare one result beat with the oldest expectation.
   function automatic void compare_result();
      session_result_type e;
      if (expected_results.size() == 0) begin
         $error("unexpected result beat: code %0d slot %0d", rsp_code, rsp_slot);
         mismatch_count++;
         return;
      end
      e = expected_results.pop_front();
      if (rsp_code !== e.code) begin
         $error("code: expected %0d, actual %0d", e.code, rsp_code);
         mismatch_count++;
      end
      if (rsp_slot !== e.slot) begin
         $error("slot: expected %0d, actual %0d", e.slot, rsp_slot);
         mismatch_count++;
      end
      if (rsp_peer_addr_hi !== e.hi) begin
         $error("peer_addr_hi: expected %h, actual %h", e.hi, rsp_peer_addr_hi);
         mismatch_count++;
      end
      if (rsp_peer_addr_lo !== e.lo) begin
         $error("peer_addr_lo: expected %h, actual %h", e.lo, rsp_peer_addr_lo);
         mismatch_count++;
      end
      if (rsp_peer_port !== e.port) begin
         $error("peer_port: expected %h, actual %h", e.port, rsp_peer_port);
         mismatch_count++;
      end
      if (rsp_error_total !== e.err) begin
         $error("error_total: expected %0d, actual %0d", e.err, rsp_error_total);
         mismatch_count++;
      end
      if (rsp_last !== e.last) begin
         $error("last: expected %0d, actual %0d", e.last, rsp_last);
         mismatch_count++;
      end
   endfunction

   initial mismatch_count = 0;

   // Results are compared before the beat accepted at the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         ka_len     <= 12'd9;
         bind_len   <= 12'd11;
         answer_len <= 12'd14;
         header_len <= 12'd56;
         frame_len  <= 12'd27;
         dead_limit <= 16'd30;
         ka_period  <= 16'd3;
         for (int i = 0; i < Slots; i++) peer_valid[i] <= 1'b0;
         bad_length_count <= '0;
         expected_results.delete();
      end else begin
         if (rsp_valid) compare_result();
         if (start && !busy) predict_session_results();
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[4:2]))
               REG_KA_LEN:     ka_len     <= pwdata[11:0];
               REG_BIND_LEN:   bind_len   <= pwdata[11:0];
               REG_ANSWER_LEN: answer_len <= pwdata[11:0];
               REG_HEADER_LEN: header_len <= pwdata[11:0];
               REG_FRAME_LEN:  frame_len  <= pwdata[11:0];
               REG_DEAD_LIMIT: dead_limit <= pwdata[15:0];
               REG_KA_PERIOD:  ka_period  <= pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Top of the peer session table testbench: clock, reset, stimulus and the verdict.
// Depends on rpst_pkg, reflector_peer_session_table_core and session_table_checker.
module testbench;
   import rpst_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int PoolSize   = 20;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_action;
   logic [63:0] req_addr_hi;
   logic [63:0] req_addr_lo;
   logic [15:0] req_src_port;
   logic [11:0] req_pkt_len;
   logic [7:0]  req_module_byte;
   logic [31:0] req_signature;
   logic        rsp_valid;
   logic [3:0]  rsp_code;
   logic [3:0]  rsp_slot;
   logic [63:0] rsp_peer_addr_hi;
   logic [63:0] rsp_peer_addr_lo;
   logic [15:0] rsp_peer_port;
   logic [31:0] rsp_error_total;
   logic        rsp_last;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          mismatch_count;
   int          results_pending;
   int          cycle_count;
   int          idle_percent;

   // Lengths currently programmed, used to aim the stimulus at each class.
   logic [11:0] class_len[5];
   logic [63:0] pool_hi[PoolSize];
   logic [63:0] pool_lo[PoolSize];
   logic [15:0] pool_port[PoolSize];

   reflector_peer_session_table_core i_dut (
      .clock, .reset, .start, .busy,
      .req_action, .req_addr_hi, .req_addr_lo, .req_src_port, .req_pkt_len,
      .req_module_byte, .req_signature,
      .rsp_valid, .rsp_code, .rsp_slot, .rsp_peer_addr_hi, .rsp_peer_addr_lo,
      .rsp_peer_port, .rsp_error_total, .rsp_last,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   session_table_checker i_checker (
      .clock, .reset, .start, .busy,
      .req_action, .req_addr_hi, .req_addr_lo, .req_src_port, .req_pkt_len,
      .req_module_byte, .req_signature,
      .rsp_valid, .rsp_code, .rsp_slot, .rsp_peer_addr_hi, .rsp_peer_addr_lo,
      .rsp_peer_port, .rsp_error_total, .rsp_last,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .mismatch_count, .results_pending
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CycleLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Offer one beat, sometimes after a random gap, and return at the edge that takes it.
   task automatic send_beat(input logic act, input logic [63:0] hi, input logic [63:0] lo,
                            input logic [15:0] port, input logic [11:0] len,
                            input logic [7:0] mod, input logic [31:0] sig);
      if ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start           <= 1'b1;
      req_action      <= act;
      req_addr_hi     <= hi;
      req_addr_lo     <= lo;
      req_src_port    <= port;
      req_pkt_len     <= len;
      req_module_byte <= mod;
      req_signature   <= sig;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   task automatic send_packet(input int peer, input logic [11:0] len, input logic [7:0] mod,
                              input logic [31:0] sig);
      send_beat(1'b0, pool_hi[peer], pool_lo[peer], pool_port[peer], len, mod, sig);
   endtask

   task automatic send_tick();
      send_beat(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                12'($urandom), 8'($urandom), $urandom);
   endtask

   // Mostly well-formed packets from a small peer pool, some ticks and some noise.
   task automatic send_random_beat();
      int          pick;
      int          peer;
      logic [11:0] len;
      logic [7:0]  mod;
      logic [31:0] sig;
      pick = $urandom_range(9);
      peer = $urandom_range(PoolSize - 1);
      case (pick)
         0, 1, 2: len = class_len[1];
         3:       len = class_len[0];
         4:       len = class_len[2];
         5:       len = class_len[3];
         6:       len = class_len[4];
         default: len = 12'($urandom);
      endcase
      case ($urandom_range(7))
         0, 1:    mod = ModSpace;
         2:       mod = ModQuit;
         default: mod = 8'($urandom);
      endcase
      sig = ($urandom_range(9) < 7) ? SigDsvt : $urandom;
      if (pick == 9)
         send_tick();
      else if ($urandom_range(9) == 0)
         send_beat(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                   len, mod, sig);
      else
         send_packet(peer, len, mod, sig);
   endtask

   // Let every expected result arrive and the block settle before touching registers.
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (results_pending != 0 || busy);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx <= REG_FRAME_LEN) class_len[idx] = value[11:0];
   endtask

   task automatic program_setting(input logic [11:0] ka, input logic [11:0] bind_l,
                                  input logic [11:0] answer, input logic [11:0] header,
                                  input logic [11:0] frame, input logic [15:0] dead,
                                  input logic [15:0] period);
      write_reg(REG_KA_LEN, 32'(ka));
      write_reg(REG_BIND_LEN, 32'(bind_l));
      write_reg(REG_ANSWER_LEN, 32'(answer));
      write_reg(REG_HEADER_LEN, 32'(header));
      write_reg(REG_FRAME_LEN, 32'(frame));
      write_reg(REG_DEAD_LIMIT, 32'(dead));
      write_reg(REG_KA_PERIOD, 32'(period));
   endtask

   // Random beats under one register setting, with the sender gap rate by overall progress.
   task automatic random_phase(inout int done, input int count);
      repeat (count) begin
         idle_percent = (done < 87) ? 32 : (done < 174) ? 49 : 0;
         send_random_beat();
         done++;
      end
      drain();
   endtask

   initial begin
      int done;
      done            = 0;
      idle_percent    = 32;
      reset           = 1'b1;
      start           = 1'b0;
      req_action      = 1'b0;
      req_addr_hi     = '0;
      req_addr_lo     = '0;
      req_src_port    = '0;
      req_pkt_len     = '0;
      req_module_byte = '0;
      req_signature   = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      class_len       = '{12'd9, 12'd11, 12'd14, 12'd56, 12'd27};
      for (int i = 0; i < PoolSize; i++) begin
         pool_hi[i]   = {$urandom, $urandom};
         pool_lo[i]   = {$urandom, $urandom};
         pool_port[i] = 16'($urandom);
      end
      // Extreme addresses, and one peer that differs from another by its port alone.
      pool_hi[2]   = '1;
      pool_lo[2]   = '1;
      pool_port[2] = '1;
      pool_hi[3]   = '0;
      pool_lo[3]   = '0;
      pool_port[3] = '0;
      pool_hi[PoolSize-1]   = pool_hi[0];
      pool_lo[PoolSize-1]   = pool_lo[0];
      pool_port[PoolSize-1] = pool_port[0] ^ 16'h0001;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under the reset register values.
      send_packet(0, 12'd11, 8'h41, 32'h0);        // bind a new peer
      send_packet(0, 12'd11, 8'h42, 32'h0);        // repeated bind
      send_packet(0, 12'd9, 8'h00, 32'h0);         // keepalive from a known peer
      send_packet(1, 12'd9, 8'h00, 32'h0);         // keepalive from an unknown peer
      send_packet(0, 12'd56, 8'h00, SigDsvt);      // stream header, good signature
      send_packet(0, 12'd27, 8'h00, 32'hFFFF_FFFF); // stream frame, bad signature
      send_packet(1, 12'd56, 8'h00, 32'h0);        // stream from an unknown peer
      send_packet(0, 12'd14, 8'h00, 32'h0);        // bind answer is ignored
      send_packet(PoolSize-1, 12'd9, 8'h00, 32'h0); // same address, other port
      send_packet(0, 12'd0, 8'hFF, 32'h0);         // bad lengths at both ends
      send_packet(0, 12'hFFF, 8'h00, 32'h0);
      send_packet(0, 12'd11, ModSpace, 32'h0);     // unbind with a space
      send_packet(1, 12'd11, 8'hFF, 32'h0);
      send_packet(1, 12'd11, ModQuit, 32'h0);      // unbind with a Q
      send_packet(1, 12'd11, ModQuit, 32'h0);      // unbind of an unknown peer
      send_packet(2, 12'd11, 8'h00, 32'h0);
      send_packet(3, 12'd11, 8'h7F, 32'h0);
      repeat (5) send_tick();                      // keepalive falls due on the fourth
      drain();

      random_phase(done, 65);
      program_setting(12'd0, 12'd4095, 12'd1, 12'd2047, 12'd100, 16'hFFFF, 16'hFFFF);
      random_phase(done, 65);
      // Equal lengths check the class priority; short limits force evictions.
      program_setting(12'd20, 12'd21, 12'd20, 12'd30, 12'd30, 16'd1, 16'd0);
      random_phase(done, 65);
      program_setting(12'd9, 12'd11, 12'd14, 12'd56, 12'd27, 16'd0, 16'd1);
      random_phase(done, 30);
      program_setting(12'd9, 12'd11, 12'd14, 12'd56, 12'd27, 16'd4, 16'd2);
      random_phase(done, 35);

      if (mismatch_count == 0 && results_pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
